// ----- rtl/rbs_pkg.sv -----
package rbs_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5,
        REG_TOL   = 3'd6
    } cfg_reg_t;

    // Request opcodes.
    localparam logic OP_CLOSEST = 1'b0;
    localparam logic OP_OCCLUDE = 1'b1;

    // Face axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Divider: input stage, range check, 31 quotient bits, saturation.
    localparam int QBITS      = 31;
    localparam int DIV_STAGES = QBITS + 3;
    // Divider plus slab ordering, reduction, multiply, hit point, face.
    localparam int PIPE_STAGES = DIV_STAGES + 5;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Request fields carried beside the dividers.
    typedef struct packed {
        logic             op;
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [31:0]      near_l;
        logic [31:0]      far_l;
        logic             in_box;
        logic             blocked;
    } side_t;

endpackage

// ----- rtl/rbs_slab_div.sv -----
module rbs_slab_div
(
    input  logic                                 clk,
    input  logic [rbs_pkg::DIV_STAGES-1:0]       en,
    input  logic signed [31:0]                   bound,
    input  logic signed [31:0]                   org,
    input  logic signed [31:0]                   dir,
    output logic signed [31:0]                   quot
);

    localparam int QB = rbs_pkg::QBITS;
    localparam int RW = 32 + QB;

    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [RW-1:0]      rem_reg  [0:QB];
    logic [31:0]        dmag_reg [0:QB+1];
    logic               neg_reg  [0:QB+1];
    logic               ovf_reg  [1:QB+1];
    logic [QB-1:0]      q_reg    [1:QB+1];
    logic [48:0]        nmag_reg;
    logic signed [31:0] quot_reg;
    logic signed [31:0] quot_next;

    // Magnitudes and quotient sign of ((bound - org) << 16) / dir.
    assign diff     = 33'(bound) - 33'(org);
    assign diff_mag = diff[32] ? 33'(-diff) : diff;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nmag_reg    <= {diff_mag, 16'b0};
            dmag_reg[0] <= dir[31] ? 32'(-dir) : 32'(dir);
            neg_reg[0]  <= diff[32] ^ dir[31];
        end
    end

    // Quotient of 2^31 or more saturates; detect it before the bit steps.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_reg[0]  <= RW'(nmag_reg);
            ovf_reg[1]  <= {14'b0, nmag_reg} >= {dmag_reg[0], 31'b0};
            dmag_reg[1] <= dmag_reg[0];
            neg_reg[1]  <= neg_reg[0];
            q_reg[1]    <= '0;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_step
            logic [RW-1:0] shd;
            logic          ge;
            assign shd = RW'(dmag_reg[k+1]) << (QB - 1 - k);
            assign ge  = rem_reg[k] >= shd;
            always_ff @(posedge clk)
            begin
                if (en[k+2])
                begin
                    rem_reg[k+1]  <= ge ? rem_reg[k] - shd : rem_reg[k];
                    dmag_reg[k+2] <= dmag_reg[k+1];
                    neg_reg[k+2]  <= neg_reg[k+1];
                    ovf_reg[k+2]  <= ovf_reg[k+1];
                    // Lower bits are still zero here, so OR in this step's bit.
                    q_reg[k+2]    <= q_reg[k+1] | (QB'(ge) << (QB - 1 - k));
                end
            end
        end
    endgenerate

    // Apply sign and saturate to the signed 32-bit range.
    always_comb
    begin
        if (ovf_reg[QB+1])
            quot_next = neg_reg[QB+1] ? rbs_pkg::Q_MIN : rbs_pkg::Q_MAX;
        else if (neg_reg[QB+1])
            quot_next = -$signed({1'b0, q_reg[QB+1]});
        else
            quot_next = $signed({1'b0, q_reg[QB+1]});
    end

    always_ff @(posedge clk)
    begin
        if (en[QB+2])
            quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

// ----- rtl/ray_box_slab_intersect_top.sv -----
// Channel  | Direction | Handshake            | Payload
// cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in       | in        | in_valid/in_stall    | opcode, origin_*, dir_*, near/far_limit
// out      | out       | out_valid/out_stall  | hit, hit_distance, face_axis
//
// One request enters every cycle while in_stall is low, and results leave in order.
// The six one-bit-per-stage dividers for the slab distances make up most of the depth.
// Reset clears all valid bits and loads the box with zero and the tolerance with one.
// Each stage holds while the stage after it is full and held, so a stalled output
// backs up the pipeline one stage at a time and empty stages keep filling.
module ray_box_slab_intersect_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] near_limit,
    input  logic signed [31:0] far_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] hit_distance,
    output logic [1:0]         face_axis
);

    localparam int DS = rbs_pkg::DIV_STAGES;
    localparam int NS = rbs_pkg::PIPE_STAGES;

    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmax_reg [3];
    logic [15:0]        tol_reg;
    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      rdy;
    rbs_pkg::side_t     side_reg [0:DS-1];
    rbs_pkg::side_t     side_next;
    logic signed [31:0] org_in [3];
    logic signed [31:0] dir_in [3];
    logic signed [31:0] qa [3];
    logic signed [31:0] qb [3];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bmin_reg[i] <= '0;
                bmax_reg[i] <= '0;
            end
            tol_reg <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbs_pkg::REG_MIN_X: bmin_reg[0] <= cfg_data;
                rbs_pkg::REG_MIN_Y: bmin_reg[1] <= cfg_data;
                rbs_pkg::REG_MIN_Z: bmin_reg[2] <= cfg_data;
                rbs_pkg::REG_MAX_X: bmax_reg[0] <= cfg_data;
                rbs_pkg::REG_MAX_Y: bmax_reg[1] <= cfg_data;
                rbs_pkg::REG_MAX_Z: bmax_reg[2] <= cfg_data;
                rbs_pkg::REG_TOL:   tol_reg     <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor moves.
    always_comb
    begin
        rdy[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int j = NS - 2; j >= 0; j--)
            rdy[j] = !v_reg[j] || rdy[j+1];
    end

    assign in_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int j = 1; j < NS; j++)
                if (rdy[j])
                    v_reg[j] <= v_reg[j-1];
        end
    end

    // Inside and zero-direction miss flags at entry.
    assign org_in = '{origin_x, origin_y, origin_z};
    assign dir_in = '{dir_x, dir_y, dir_z};

    always_comb
    begin
        side_next.op      = opcode;
        side_next.near_l  = near_limit;
        side_next.far_l   = far_limit;
        side_next.in_box  = 1'b1;
        side_next.blocked = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            side_next.org[i] = org_in[i];
            side_next.dir[i] = dir_in[i];
            if (!(bmin_reg[i] <= org_in[i] && org_in[i] <= bmax_reg[i]))
            begin
                side_next.in_box = 1'b0;
                if (dir_in[i] == '0)
                    side_next.blocked = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            side_reg[0] <= side_next;
        for (int j = 1; j < DS; j++)
            if (rdy[j])
                side_reg[j] <= side_reg[j-1];
    end

    // Two slab distances per axis.
    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            rbs_slab_div u_div_min
            (
                .clk   (clk),
                .en    (rdy[DS-1:0]),
                .bound (bmin_reg[a]),
                .org   (org_in[a]),
                .dir   (dir_in[a]),
                .quot  (qa[a])
            );
            rbs_slab_div u_div_max
            (
                .clk   (clk),
                .en    (rdy[DS-1:0]),
                .bound (bmax_reg[a]),
                .org   (org_in[a]),
                .dir   (dir_in[a]),
                .quot  (qb[a])
            );
        end
    endgenerate

    // Order each pair into entry and exit distance.
    rbs_pkg::side_t     s1_reg;
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [2:0]         bnd_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[DS])
        begin
            s1_reg <= side_reg[DS-1];
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= (qa[i] < qb[i]) ? qa[i] : qb[i];
                hi_reg[i]  <= (qa[i] < qb[i]) ? qb[i] : qa[i];
                bnd_reg[i] <= side_reg[DS-1].dir[i] != '0;
            end
        end
    end

    // Largest entry and smallest exit over the bounding axes.
    rbs_pkg::side_t     s2_reg;
    logic signed [31:0] t1_next, t2_next, t1_reg, t2_reg;
    logic               has_next, has_reg;

    always_comb
    begin
        t1_next  = rbs_pkg::Q_MIN;
        t2_next  = rbs_pkg::Q_MAX;
        has_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (bnd_reg[i])
            begin
                if (!has_next || lo_reg[i] > t1_next)
                    t1_next = lo_reg[i];
                if (!has_next || hi_reg[i] < t2_next)
                    t2_next = hi_reg[i];
                has_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[DS+1])
        begin
            s2_reg  <= s1_reg;
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            has_reg <= has_next;
        end
    end

    // Hit decision and the hit point products for x and y.
    logic               hit3_reg, hit3_next, op3_reg;
    logic signed [31:0] t3_reg, far3_reg;
    logic signed [31:0] org3_reg [2];
    logic signed [63:0] prod_reg [2];
    logic               range_ok;

    assign range_ok = !s2_reg.blocked && has_reg &&
                      t1_reg >= $signed(s2_reg.near_l) && t1_reg <= $signed(s2_reg.far_l);

    always_comb
    begin
        if (s2_reg.op == rbs_pkg::OP_OCCLUDE)
            hit3_next = s2_reg.in_box || (range_ok && t1_reg < t2_reg);
        else
            hit3_next = range_ok && t1_reg <= t2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[DS+2])
        begin
            hit3_reg <= hit3_next;
            op3_reg  <= s2_reg.op;
            t3_reg   <= t1_reg;
            far3_reg <= s2_reg.far_l;
            for (int i = 0; i < 2; i++)
            begin
                org3_reg[i] <= s2_reg.org[i];
                prod_reg[i] <= t1_reg * $signed(s2_reg.dir[i]);
            end
        end
    end

    // Hit point: origin plus product floored to Q16.16, full width.
    logic               hit4_reg, op4_reg;
    logic signed [31:0] t4_reg, far4_reg;
    logic signed [48:0] pt_reg [2];

    always_ff @(posedge clk)
    begin
        if (rdy[DS+3])
        begin
            hit4_reg <= hit3_reg;
            op4_reg  <= op3_reg;
            t4_reg   <= t3_reg;
            far4_reg <= far3_reg;
            for (int i = 0; i < 2; i++)
                pt_reg[i] <= 49'(org3_reg[i]) + 49'(prod_reg[i] >>> 16);
        end
    end

    // Face match against the minimum corner and the output register.
    logic signed [49:0] fd [2];
    logic [49:0]        fmag [2];
    logic [1:0]         match;
    logic               hit_reg;
    logic signed [31:0] dist_reg;
    logic [1:0]         face_reg, face_next;
    logic               closest;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            fd[i]    = 50'(bmin_reg[i]) - 50'(pt_reg[i]);
            fmag[i]  = fd[i][49] ? 50'(-fd[i]) : 50'(fd[i]);
            match[i] = fmag[i] < 50'(tol_reg);
        end
    end

    assign closest = hit4_reg && op4_reg == rbs_pkg::OP_CLOSEST;

    always_comb
    begin
        if (!closest)
            face_next = rbs_pkg::AXIS_X;
        else if (match[0])
            face_next = rbs_pkg::AXIS_X;
        else if (match[1])
            face_next = rbs_pkg::AXIS_Y;
        else
            face_next = rbs_pkg::AXIS_Z;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            hit_reg  <= hit4_reg;
            dist_reg <= closest ? t4_reg : far4_reg;
            face_reg <= face_next;
        end
    end

    assign out_valid    = v_reg[NS-1];
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign face_axis    = face_reg;

    // Input can only be held back when the whole pipeline is full and the output waits.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg) && out_stall)
        else $error("input stalled with room in the pipeline");

    // A miss always reports the AXIS_X face code.
    a_miss_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> face_axis == rbs_pkg::AXIS_X)
        else $error("face reported on a miss");

    // The face code stays within the three axes.
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> face_axis == rbs_pkg::AXIS_X || face_axis == rbs_pkg::AXIS_Y ||
                      face_axis == rbs_pkg::AXIS_Z)
        else $error("face code out of range");

    // A result held at the output moves the stage behind it nowhere.
    a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && v_reg[NS-2] |=> v_reg[NS-2] && v_reg[NS-1])
        else $error("request lost behind a held result");

endmodule

// ----- sim/tb_ray_box_slab_intersect_top.sv -----
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect_top;

    // Index that the block has no register for.
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam longint Q_ONE = 64'sd65536;
    localparam int DRAIN_CYCLES = rbs_pkg::PIPE_STAGES + 12;

    typedef struct packed {
        logic             op;
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [31:0]      near_l;
        logic [31:0]      far_l;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hdist;
        logic [1:0]  face;
    } hit_t;

    typedef struct packed {
        ray_t r;
        logic known;
        hit_t res;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    ray_t               ray = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit;
    logic signed [31:0] hit_distance;
    logic [1:0]         face_axis;

    // Outputs captured at the falling edge, used at the next rising edge.
    logic        s_in_stall, s_cfg_ready, s_out_valid;
    hit_t        s_res;

    // Box copy used by the predictor.
    longint box_lo [3];
    longint box_hi [3];
    longint face_tol;

    hit_t   pending_hits [$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    row_t   rows [$];

    ray_box_slab_intersect_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (ray.op),
        .origin_x     (ray.org[0]),
        .origin_y     (ray.org[1]),
        .origin_z     (ray.org[2]),
        .dir_x        (ray.dir[0]),
        .dir_y        (ray.dir[1]),
        .dir_z        (ray.dir[2]),
        .near_limit   (ray.near_l),
        .far_limit    (ray.far_l),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_distance (hit_distance),
        .face_axis    (face_axis)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(negedge clk)
    begin
        s_in_stall  <= in_stall;
        s_cfg_ready <= cfg_ready;
        s_out_valid <= out_valid;
        s_res       <= '{hit, hit_distance, face_axis};
    end

    // Distance to one slab plane, truncated toward zero and saturated.
    function automatic longint plane_dist(longint bound, longint o, longint d);
        longint q;
        q = ((bound - o) * Q_ONE) / d;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic hit_t trace_box(ray_t r);
        longint o [3];
        longint d [3];
        longint t1, t2, a, b, p, df;
        bit     blocked, in_box;
        hit_t   res;
        t1 = -(64'sd1 <<< 40);
        t2 = 64'sd1 <<< 40;
        blocked = 1'b0;
        in_box = 1'b1;
        res = '{1'b0, r.far_l, rbs_pkg::AXIS_X};
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'($signed(r.org[i]));
            d[i] = longint'($signed(r.dir[i]));
            if (!(box_lo[i] <= o[i] && o[i] <= box_hi[i]))
                in_box = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (d[i] == 0)
            begin
                if (!(box_lo[i] <= o[i] && o[i] <= box_hi[i]))
                    blocked = 1'b1;
            end
            else
            begin
                a = plane_dist(box_lo[i], o[i], d[i]);
                b = plane_dist(box_hi[i], o[i], d[i]);
                if (a > b)
                begin
                    p = a;
                    a = b;
                    b = p;
                end
                if (a > t1)
                    t1 = a;
                if (b < t2)
                    t2 = b;
            end
        end
        if (r.op == rbs_pkg::OP_OCCLUDE && in_box)
            res.hit = 1'b1;
        else if (!blocked && t1 >= longint'($signed(r.near_l))
                 && t1 <= longint'($signed(r.far_l)))
        begin
            if (r.op == rbs_pkg::OP_OCCLUDE)
                res.hit = (t1 < t2);
            else if (t1 <= t2)
            begin
                res.hit = 1'b1;
                res.hdist = t1[31:0];
                res.face = rbs_pkg::AXIS_Z;
                // Only the x and y minimum faces are compared.
                for (int i = 0; i < 2; i++)
                begin
                    p = o[i] + ((t1 * d[i]) >>> 16);
                    df = box_lo[i] - p;
                    if (df < 0)
                        df = -df;
                    if (df < face_tol)
                    begin
                        res.face = (i == 0) ? rbs_pkg::AXIS_X : rbs_pkg::AXIS_Y;
                        break;
                    end
                end
            end
        end
        return res;
    endfunction

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && s_out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result: hit %0d distance %0h", s_res.hit, s_res.hdist);
                errors++;
            end
            else
            begin
                hit_t want;
                want = pending_hits.pop_front();
                if (want.hit !== s_res.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, s_res.hit);
                    errors++;
                end
                if (want.hdist !== s_res.hdist)
                begin
                    $error("hit_distance: expected %0h, got %0h", want.hdist, s_res.hdist);
                    errors++;
                end
                if (want.face !== s_res.face)
                begin
                    $error("face_axis: expected %0d, got %0d", want.face, s_res.face);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!s_cfg_ready);
        if (idx < rbs_pkg::REG_MAX_X)
            box_lo[idx] = longint'($signed(value));
        else if (idx <= rbs_pkg::REG_MAX_Z)
            box_hi[idx - rbs_pkg::REG_MAX_X] = longint'($signed(value));
        else if (idx == rbs_pkg::REG_TOL)
            face_tol = longint'(value[15:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                            logic [15:0] tol);
        write_reg(rbs_pkg::REG_MIN_X, lx);
        write_reg(rbs_pkg::REG_MIN_Y, ly);
        write_reg(rbs_pkg::REG_MIN_Z, lz);
        write_reg(rbs_pkg::REG_MAX_X, hx);
        write_reg(rbs_pkg::REG_MAX_Y, hy);
        write_reg(rbs_pkg::REG_MAX_Z, hz);
        write_reg(rbs_pkg::REG_TOL, {16'($urandom_range(0, 65535)), tol});
        write_reg(REG_NONE, $urandom);
    endtask

    // Offer one request, with random idle cycles ahead of it. Valid stays high
    // after acceptance so that requests can follow back to back.
    task automatic send_ray(ray_t r, logic known, hit_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ray <= r;
        do
            @(posedge clk);
        while (s_in_stall);
        pending_hits.push_back(known ? res : trace_box(r));
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return rbs_pkg::Q_MAX;
        if (v < -64'sd2147483648)
            return rbs_pkg::Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 7))
            0: return rbs_pkg::Q_MIN;
            1: return rbs_pkg::Q_MAX;
            2: return 32'd0;
            3, 4: return $urandom;
            default: return clamp32(longint'($urandom_range(0, 16 << 16)) - (8 << 16));
        endcase
    endfunction

    function automatic ray_t make_ray();
        ray_t   r;
        longint tgt, o, span;
        r.op = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 25)
        begin
            // Noise: every field unconstrained.
            for (int i = 0; i < 3; i++)
            begin
                r.org[i] = pick_q();
                r.dir[i] = pick_q();
            end
            r.near_l = pick_q();
            r.far_l = pick_q();
            return r;
        end
        // Aim from a point near the box at a point inside it.
        for (int i = 0; i < 3; i++)
        begin
            span = box_hi[i] - box_lo[i];
            if (span < 0)
                span = -span;
            tgt = box_lo[i] + (longint'($urandom_range(0, 1024)) * span) / 1024;
            o = tgt + longint'($urandom_range(0, 32 << 16)) - (16 << 16);
            r.org[i] = clamp32(o);
            r.dir[i] = ($urandom_range(0, 9) == 0) ? 32'd0
                       : clamp32(tgt - longint'($signed(r.org[i])));
        end
        r.near_l = ($urandom_range(0, 3) == 0) ? pick_q() : 32'd0;
        r.far_l = ($urandom_range(0, 3) == 0) ? pick_q() : 32'h0040_0000;
        return r;
    endfunction

    function automatic row_t make_row(logic op, logic [31:0] ox, logic [31:0] oy,
                                      logic [31:0] oz, logic [31:0] dx, logic [31:0] dy,
                                      logic [31:0] dz, logic [31:0] nl, logic [31:0] fl,
                                      logic known, logic h, logic [31:0] dval,
                                      logic [1:0] face);
        row_t w;
        w.r = '{op, {oz, oy, ox}, {dz, dy, dx}, nl, fl};
        w.known = known;
        w.res = '{h, dval, face};
        return w;
    endfunction

    task automatic run_rows();
        foreach (rows[i])
            send_ray(rows[i].r, rows[i].known, rows[i].res);
        rows.delete();
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        face_tol = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset box a point at the origin lies inside it.
        rows.push_back(make_row(rbs_pkg::OP_OCCLUDE, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678,
                                1'b1, 1'b1, 32'h1234_5678, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 0, 0, 0, 0, 0, 0, 0, rbs_pkg::Q_MAX,
                                1'b1, 1'b0, rbs_pkg::Q_MAX, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 32'hFFFF_0000, 0, 0, 32'h0001_0000,
                                0, 0, 0, rbs_pkg::Q_MAX, 1'b0, 1'b0, 0, 2'd0));
        run_rows();

        // Unit box, rays along each axis and the corner cases.
        load_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0100);
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 32'hFFFC_0000, 0, 0, 32'h0001_0000,
                                0, 0, 0, 32'h0010_0000,
                                1'b1, 1'b1, 32'h0003_0000, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 0, 32'h0005_0000, 0, 32'h0001_0000,
                                0, 0, 0, 32'h0010_0000,
                                1'b1, 1'b0, 32'h0010_0000, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_OCCLUDE, 0, 0, 0, 32'h0001_0000, 0, 0,
                                0, 32'h0010_0000,
                                1'b1, 1'b1, 32'h0010_0000, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 0, 0, 0, 0, 0, 0, 0, rbs_pkg::Q_MAX,
                                1'b1, 1'b0, rbs_pkg::Q_MAX, rbs_pkg::AXIS_X));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 0, 32'hFFFC_0000, 0, 0, 32'h0001_0000,
                                0, 0, 32'h0010_0000, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 0, 0, 32'hFFFC_0000, 0, 0,
                                32'h0001_0000, 0, 32'h0010_0000, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_OCCLUDE, 32'hFFFC_0000, 0, 0, 32'h0001_0000,
                                0, 0, 0, 32'h0010_0000, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 32'hFFFC_0000, 0, 0, 32'h0001_0000,
                                0, 0, 32'h0004_0000, 32'h0002_0000, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, rbs_pkg::Q_MIN, 0, 0, 32'h0000_0001,
                                0, 0, rbs_pkg::Q_MIN, rbs_pkg::Q_MAX,
                                1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, rbs_pkg::Q_MAX, rbs_pkg::Q_MAX,
                                rbs_pkg::Q_MAX, rbs_pkg::Q_MIN, rbs_pkg::Q_MIN,
                                rbs_pkg::Q_MIN, rbs_pkg::Q_MIN, rbs_pkg::Q_MAX,
                                1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_OCCLUDE, rbs_pkg::Q_MIN, rbs_pkg::Q_MIN,
                                rbs_pkg::Q_MIN, rbs_pkg::Q_MAX, rbs_pkg::Q_MAX,
                                rbs_pkg::Q_MAX, rbs_pkg::Q_MIN, rbs_pkg::Q_MAX,
                                1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 32'h0000_8000, 32'hFFFC_0000, 0, 0,
                                32'h0001_0000, 32'hFFFF_FFFF, rbs_pkg::Q_MIN,
                                rbs_pkg::Q_MAX, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_OCCLUDE, 32'hFFFC_0000, 32'hFFFC_0000,
                                32'hFFFC_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 0, 32'h0010_0000, 1'b0, 1'b0, 0, 2'd0));
        rows.push_back(make_row(rbs_pkg::OP_CLOSEST, 32'hFFFC_0000, 32'hFFFC_0000,
                                32'hFFFC_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 0, 32'h0010_0000, 1'b0, 1'b0, 0, 2'd0));
        run_rows();

        // Random phases, one box setting and one idle pattern each.
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = 0;
            stall_pct = 0;
            case (ph)
                0: load_box(32'hFFFE_0000, 32'hFFFF_0000, 32'hFFFD_0000,
                            32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 16'h0000);
                1: load_box(rbs_pkg::Q_MIN, rbs_pkg::Q_MIN, rbs_pkg::Q_MIN,
                            rbs_pkg::Q_MAX, rbs_pkg::Q_MAX, rbs_pkg::Q_MAX, 16'hFFFF);
                // Inverted on x and z.
                2: load_box(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000,
                            32'hFFFE_0000, 32'h0001_0000, 32'hFFFF_0000, 16'h8000);
                3: load_box(rbs_pkg::Q_MAX, rbs_pkg::Q_MAX, rbs_pkg::Q_MAX,
                            rbs_pkg::Q_MIN, rbs_pkg::Q_MIN, rbs_pkg::Q_MIN, 16'h0001);
                default:
                begin
                    logic [31:0] lo [3];
                    for (int i = 0; i < 3; i++)
                        lo[i] = pick_q();
                    load_box(lo[0], lo[1], lo[2],
                             clamp32(longint'($signed(lo[0]))
                                     + longint'($urandom_range(0, 8 << 16))),
                             clamp32(longint'($signed(lo[1]))
                                     + longint'($urandom_range(0, 8 << 16))),
                             clamp32(longint'($signed(lo[2]))
                                     + longint'($urandom_range(0, 8 << 16))),
                             16'($urandom_range(0, 65535)));
                end
            endcase
            case (ph % 4)
                1: send_idle_pct = 64;
                2: stall_pct = 64;
                3:
                begin
                    send_idle_pct = 23;
                    stall_pct = 23;
                end
                default: ;
            endcase
            repeat (60)
                send_ray(make_ray(), 1'b0, '0);
            drain();
        end

        stall_pct = 0;
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
